### src/c8_pkg.sv
// ----------------------------------------------------------------------------
// c8_pkg: shared types and constants of the CHIP-8 instruction core
// Item structs, request structs between the core and its memories,
// sequencer states, status codes and the hex font table.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MEM_AW  = 12;   // 4096 bytes of main memory
  localparam int FB_ROWS = 32;
  localparam int FB_AW   = 5;
  localparam int FB_W    = 64;
  localparam int FONT_BYTES = 80;

  // Item kinds.
  localparam logic [1:0] OPC_WRITE = 2'd0;
  localparam logic [1:0] OPC_READ  = 2'd1;
  localparam logic [1:0] OPC_EXEC  = 2'd2;
  localparam logic [1:0] OPC_ROW   = 2'd3;

  // Step status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_BADOP = 3'd2;
  localparam logic [2:0] ST_STACK = 3'd3;
  localparam logic [2:0] ST_HALT  = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] address;
    logic [7:0]  write_byte;
    logic [15:0] keys_down;
    logic        key_press_event;
    logic [3:0]  last_key;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [63:0] display_row;
    logic [11:0] program_counter;
    logic        sound_on;
    logic [2:0]  step_status;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic             we;
    logic             clr_all;
    logic [FB_AW-1:0] addr;
    logic [FB_W-1:0]  wdata;
  } fb_req_t;

  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    logic [7:0] wdata;
    logic [3:0] raddr_a;
    logic [3:0] raddr_b;
  } vreg_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDMEM,
    S_RDROW,
    S_FETCH_HI,
    S_FETCH_LO,
    S_DECODE,
    S_WRVX,
    S_DRAW_RD,
    S_DRAW_WR,
    S_DRAW_FLAG,
    S_BCD,
    S_ST_RD,
    S_ST_WR,
    S_LD_RD,
    S_LD_WR,
    S_FINISH
  } state_t;

  localparam logic [7:0] FONT_GLYPHS [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

### src/c8_mem.sv
// ----------------------------------------------------------------------------
// c8_mem: main memory
// 4096 x 8 single-port synchronous RAM. After reset a sweep writes the font
// glyphs and zeroes the rest, one byte per cycle, while busy_o is high.
// ----------------------------------------------------------------------------
module c8_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  c8_pkg::mem_req_t req_i,
  output logic [7:0]       rdata_o,
  output logic             busy_o
);
  import c8_pkg::*;

  logic [7:0]      mem [2**MEM_AW];
  logic [MEM_AW:0] clr_cnt_r;
  logic [7:0]      clr_data;

  assign busy_o = ~clr_cnt_r[MEM_AW];

  always_comb begin
    clr_data = 8'd0;
    if (clr_cnt_r < (MEM_AW+1)'(FONT_BYTES)) begin
      clr_data = FONT_GLYPHS[clr_cnt_r[6:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (busy_o) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_o) begin
      mem[clr_cnt_r[MEM_AW-1:0]] <= clr_data;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

### src/c8_fb.sv
// ----------------------------------------------------------------------------
// c8_fb: framebuffer
// 32 rows of 64 pixels in a synchronous RAM. A row that is not marked valid
// reads as blank, so a screen clear only drops the valid bits.
// ----------------------------------------------------------------------------
module c8_fb (
  input  logic                   clk,
  input  logic                   rst_n,
  input  c8_pkg::fb_req_t        req_i,
  output logic [c8_pkg::FB_W-1:0] rdata_o
);
  import c8_pkg::*;

  logic [FB_W-1:0]    mem [FB_ROWS];
  logic [FB_ROWS-1:0] vld_r;
  logic [FB_W-1:0]    rd_r;
  logic               rd_vld_r;

  assign rdata_o = rd_vld_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req_i.clr_all) begin
      vld_r <= '0;
    end else if (req_i.we) begin
      vld_r[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rd_r     <= mem[req_i.addr];
    rd_vld_r <= vld_r[req_i.addr];
  end

endmodule

### src/c8_vregs.sv
// ----------------------------------------------------------------------------
// c8_vregs: data register file
// Sixteen byte registers V0..VF, one write port and two registered read
// ports. Registers never written since reset read as zero.
// ----------------------------------------------------------------------------
module c8_vregs (
  input  logic              clk,
  input  logic              rst_n,
  input  c8_pkg::vreg_req_t req_i,
  output logic [7:0]        rdata_a_o,
  output logic [7:0]        rdata_b_o
);
  import c8_pkg::*;

  logic [7:0]  mem [16];
  logic [15:0] vld_r;
  logic [7:0]  rd_a_r;
  logic [7:0]  rd_b_r;
  logic        vld_a_r;
  logic        vld_b_r;

  assign rdata_a_o = vld_a_r ? rd_a_r : 8'd0;
  assign rdata_b_o = vld_b_r ? rd_b_r : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req_i.we) begin
      vld_r[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_r  <= mem[req_i.raddr_a];
    rd_b_r  <= mem[req_i.raddr_b];
    vld_a_r <= vld_r[req_i.raddr_a];
    vld_b_r <= vld_r[req_i.raddr_b];
  end

endmodule

### src/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 interpreter core
// Sequencer around main memory, framebuffer and register file RAMs.
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer whose every step is one
// access to the single-port main memory, the framebuffer or the register
// file. Most instructions pass through two fetch reads, a register read,
// execute and result; ALU ops that set VF add a second register write, and
// BCD, sprite draws and FX55/FX65 add a loop over their bytes or rows. After
// reset the core sweeps main memory to load the font, holding in_stall high
// meanwhile. A finished result waits in an output register, so the next
// item is taken while it is still stalled.
// ----------------------------------------------------------------------------
module chip8_instruction_core #(
  parameter int STACK_DEPTH   = 16,
  parameter int PROGRAM_START = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  c8_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output c8_pkg::out_item_t out_data
);
  import c8_pkg::*;

  localparam int SP_IW = $clog2(STACK_DEPTH);

  state_t     state_r, state_nxt;
  in_item_t   item_r, item_nxt;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [15:0] op_r, op_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [4:0]  sp_r, sp_nxt;
  logic [7:0]  dt_r, dt_nxt;
  logic [7:0]  st_r, st_nxt;
  logic        halted_r, halted_nxt;
  logic        exec_r, exec_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  rbyte_r, rbyte_nxt;
  logic [63:0] row_r, row_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        hit_r, hit_nxt;
  logic [7:0]  res_r, res_nxt;
  logic [7:0]  va_r, va_nxt;
  logic [7:0]  vb_r, vb_nxt;
  logic [1:0]  bcd_h_r, bcd_h_nxt;
  logic [6:0]  bcd_rem_r, bcd_rem_nxt;
  logic [11:0] stk_r [STACK_DEPTH];

  mem_req_t    mem_req;
  fb_req_t     fb_req;
  vreg_req_t   v_req;
  logic [7:0]  mem_rdata;
  logic        mem_busy;
  logic [63:0] fb_rdata;
  logic [7:0]  va, vb;
  logic        push_en;

  logic [15:0] opw;
  logic [3:0]  x, n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [8:0]  sum9;
  logic        held;
  logic [4:0]  sp_m1;
  logic [63:0] spr_bits;
  logic [127:0] spr_dbl;
  logic [4:0]  draw_line;
  logic [11:0] i_addr;
  logic [15:0] hund_prod;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [7:0]  ones;
  logic [7:0]  bcd_digit;
  logic [7:0]  dt_dec, st_dec;

  c8_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  c8_fb u_fb (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (fb_req),
    .rdata_o (fb_rdata)
  );

  c8_vregs u_vregs (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (v_req),
    .rdata_a_o (va),
    .rdata_b_o (vb)
  );

  assign in_stall  = (state_r != S_IDLE) || mem_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Instruction fields and shared datapath pieces.
  assign opw  = {op_r[15:8], mem_rdata};
  assign x    = op_r[11:8];
  assign n    = op_r[3:0];
  assign kk   = op_r[7:0];
  assign nnn  = op_r[11:0];
  assign sp_m1 = sp_r - 5'd1;
  assign i_addr = i_r[11:0] + {8'd0, cnt_r};
  assign draw_line = vb_r[4:0] + {1'b0, cnt_r};

  // Sprite byte rotated right by the x coordinate, wrapping at the edge.
  assign spr_bits = {mem_rdata, 56'd0};
  assign spr_dbl  = {spr_bits, spr_bits} >> va_r[5:0];

  // Digits by reciprocal multiplication; exact over the ranges used here.
  assign hund_prod = 16'(va) * 16'd41;
  assign tens_prod = 15'(bcd_rem_r) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = 8'(bcd_rem_r) - 8'(tens) * 8'd10;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h_r};
      2'd1:    bcd_digit = {4'd0, tens};
      default: bcd_digit = ones;
    endcase
  end

  assign dt_dec = (dt_r != 8'd0) ? dt_r - 8'd1 : dt_r;
  assign st_dec = (st_r != 8'd0) ? st_r - 8'd1 : st_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    op_nxt        = op_r;
    pc_nxt        = pc_r;
    i_nxt         = i_r;
    sp_nxt        = sp_r;
    dt_nxt        = dt_r;
    st_nxt        = st_r;
    halted_nxt    = halted_r;
    exec_nxt      = exec_r;
    status_nxt    = status_r;
    rbyte_nxt     = rbyte_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    bcd_h_nxt     = bcd_h_r;
    bcd_rem_nxt   = bcd_rem_r;
    mem_req       = '0;
    fb_req        = '0;
    v_req         = '0;
    push_en       = 1'b0;
    sum9          = 9'd0;
    held          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          item_nxt   = in_data;
          rbyte_nxt  = 8'd0;
          row_nxt    = '0;
          exec_nxt   = 1'b0;
          status_nxt = halted_r ? ST_HALT : ST_OK;
          case (in_data.opcode)
            OPC_WRITE: begin
              mem_req.we    = 1'b1;
              mem_req.addr  = in_data.address;
              mem_req.wdata = in_data.write_byte;
              state_nxt     = S_FINISH;
            end
            OPC_READ: begin
              mem_req.addr = in_data.address;
              state_nxt    = S_RDMEM;
            end
            OPC_ROW: begin
              fb_req.addr = in_data.address[FB_AW-1:0];
              state_nxt   = S_RDROW;
            end
            default: begin
              if (halted_r) begin
                state_nxt = S_FINISH;
              end else begin
                exec_nxt     = 1'b1;
                mem_req.addr = pc_r;
                state_nxt    = S_FETCH_HI;
              end
            end
          endcase
        end
      end

      S_RDMEM: begin
        rbyte_nxt = mem_rdata;
        state_nxt = S_FINISH;
      end

      S_RDROW: begin
        row_nxt   = fb_rdata;
        state_nxt = S_FINISH;
      end

      S_FETCH_HI: begin
        op_nxt[15:8] = mem_rdata;
        mem_req.addr = pc_r + 12'd1;
        state_nxt    = S_FETCH_LO;
      end

      S_FETCH_LO: begin
        op_nxt = opw;
        // BNNN needs V0 rather than Vx on the first read port.
        v_req.raddr_a = (opw[15:12] == 4'hB) ? 4'h0 : opw[11:8];
        v_req.raddr_b = opw[7:4];
        pc_nxt    = pc_r + 12'd2;
        cnt_nxt   = 4'd0;
        hit_nxt   = 1'b0;
        state_nxt = S_DECODE;
      end

      S_DECODE: begin
        va_nxt      = va;
        vb_nxt      = vb;
        bcd_h_nxt   = hund_prod[13:12];
        bcd_rem_nxt = 7'(va - 8'(hund_prod[13:12]) * 8'd100);
        v_req.waddr = x;
        state_nxt   = S_FINISH;
        case (op_r[15:12])
          4'h0: begin
            if (op_r == 16'h00E0) begin
              fb_req.clr_all = 1'b1;
            end else if (op_r == 16'h00EE) begin
              if (sp_r == 5'd0 || sp_r > 5'(STACK_DEPTH)) begin
                halted_nxt = 1'b1;
                status_nxt = ST_STACK;
              end else begin
                sp_nxt = sp_m1;
                pc_nxt = stk_r[sp_m1[SP_IW-1:0]];
              end
            end else begin
              status_nxt = ST_BADOP;
            end
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            if (sp_r >= 5'(STACK_DEPTH)) begin
              halted_nxt = 1'b1;
              status_nxt = ST_STACK;
            end else begin
              push_en = 1'b1;
              sp_nxt  = sp_r + 5'd1;
              pc_nxt  = nnn;
            end
          end
          4'h3: if (va == kk) pc_nxt = pc_r + 12'd2;
          4'h4: if (va != kk) pc_nxt = pc_r + 12'd2;
          4'h5: if (va == vb) pc_nxt = pc_r + 12'd2;
          4'h9: if (va != vb) pc_nxt = pc_r + 12'd2;
          4'h6: begin
            v_req.we    = 1'b1;
            v_req.wdata = kk;
          end
          4'h7: begin
            v_req.we    = 1'b1;
            v_req.wdata = va + kk;
          end
          4'h8: begin
            v_req.we = 1'b1;
            case (n)
              4'h0: v_req.wdata = vb;
              4'h1: v_req.wdata = va | vb;
              4'h2: v_req.wdata = va & vb;
              4'h3: v_req.wdata = va ^ vb;
              4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                // The flag goes in first so that Vx lands on top when X is F.
                v_req.waddr = 4'hF;
                state_nxt   = S_WRVX;
                case (n)
                  4'h4: begin
                    sum9        = {1'b0, va} + {1'b0, vb};
                    v_req.wdata = {7'd0, sum9[8]};
                    res_nxt     = sum9[7:0];
                  end
                  4'h5: begin
                    v_req.wdata = {7'd0, va > vb};
                    res_nxt     = va - vb;
                  end
                  4'h6: begin
                    v_req.wdata = {7'd0, va[0]};
                    res_nxt     = {1'b0, va[7:1]};
                  end
                  4'h7: begin
                    v_req.wdata = {7'd0, vb > va};
                    res_nxt     = vb - va;
                  end
                  default: begin
                    v_req.wdata = {7'd0, va[7]};
                    res_nxt     = {va[6:0], 1'b0};
                  end
                endcase
              end
              default: begin
                v_req.we   = 1'b0;
                status_nxt = ST_BADOP;
              end
            endcase
          end
          4'hA: i_nxt  = {4'd0, nnn};
          4'hB: pc_nxt = nnn + {4'd0, va};
          4'hC: begin
            v_req.we    = 1'b1;
            v_req.wdata = item_r.random_byte & kk;
          end
          4'hD: begin
            if (n == 4'd0) begin
              v_req.we    = 1'b1;
              v_req.waddr = 4'hF;
              v_req.wdata = 8'd0;
            end else begin
              state_nxt = S_DRAW_RD;
            end
          end
          4'hE: begin
            held = (va < 8'd16) && item_r.keys_down[va[3:0]];
            if (kk == 8'h9E) begin
              if (held) pc_nxt = pc_r + 12'd2;
            end else if (kk == 8'hA1) begin
              if (!held) pc_nxt = pc_r + 12'd2;
            end else begin
              status_nxt = ST_BADOP;
            end
          end
          default: begin
            case (kk)
              8'h07: begin
                v_req.we    = 1'b1;
                v_req.wdata = dt_r;
              end
              8'h0A: begin
                if (item_r.key_press_event) begin
                  v_req.we    = 1'b1;
                  v_req.wdata = {4'd0, item_r.last_key};
                end else begin
                  pc_nxt     = pc_r - 12'd2;
                  status_nxt = ST_WAIT;
                end
              end
              8'h15: dt_nxt = va;
              8'h18: st_nxt = va;
              8'h1E: i_nxt  = i_r + {8'd0, va};
              8'h29: i_nxt  = {6'd0, va, 2'd0} + {8'd0, va};
              8'h33: state_nxt = S_BCD;
              8'h55: state_nxt = S_ST_RD;
              8'h65: state_nxt = S_LD_RD;
              default: status_nxt = ST_BADOP;
            endcase
          end
        endcase
      end

      S_WRVX: begin
        v_req.we    = 1'b1;
        v_req.waddr = x;
        v_req.wdata = res_r;
        state_nxt   = S_FINISH;
      end

      S_DRAW_RD: begin
        mem_req.addr = i_addr;
        fb_req.addr  = draw_line;
        state_nxt    = S_DRAW_WR;
      end

      S_DRAW_WR: begin
        if ((fb_rdata & spr_dbl[63:0]) != '0) hit_nxt = 1'b1;
        fb_req.we    = 1'b1;
        fb_req.addr  = draw_line;
        fb_req.wdata = fb_rdata ^ spr_dbl[63:0];
        cnt_nxt      = cnt_r + 4'd1;
        state_nxt    = (cnt_r == n - 4'd1) ? S_DRAW_FLAG : S_DRAW_RD;
      end

      S_DRAW_FLAG: begin
        v_req.we    = 1'b1;
        v_req.waddr = 4'hF;
        v_req.wdata = {7'd0, hit_r};
        state_nxt   = S_FINISH;
      end

      S_BCD: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = i_addr;
        mem_req.wdata = bcd_digit;
        cnt_nxt       = cnt_r + 4'd1;
        if (cnt_r == 4'd2) state_nxt = S_FINISH;
      end

      S_ST_RD: begin
        v_req.raddr_a = cnt_r;
        state_nxt     = S_ST_WR;
      end

      S_ST_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = i_addr;
        mem_req.wdata = va;
        cnt_nxt       = cnt_r + 4'd1;
        state_nxt     = (cnt_r == x) ? S_FINISH : S_ST_RD;
      end

      S_LD_RD: begin
        mem_req.addr = i_addr;
        state_nxt    = S_LD_WR;
      end

      S_LD_WR: begin
        v_req.we    = 1'b1;
        v_req.waddr = cnt_r;
        v_req.wdata = mem_rdata;
        cnt_nxt     = cnt_r + 4'd1;
        state_nxt   = (cnt_r == x) ? S_FINISH : S_LD_RD;
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_nxt.read_byte       = rbyte_r;
          out_nxt.display_row     = row_r;
          out_nxt.program_counter = pc_r;
          out_nxt.step_status     = status_r;
          out_nxt.sound_on        = exec_r ? (st_dec != 8'd0) : (st_r != 8'd0);
          if (exec_r) begin
            dt_nxt = dt_dec;
            st_nxt = st_dec;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= 12'(PROGRAM_START);
      i_r         <= '0;
      sp_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      halted_r    <= 1'b0;
      exec_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      dt_r        <= dt_nxt;
      st_r        <= st_nxt;
      halted_r    <= halted_nxt;
      exec_r      <= exec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_r     <= out_nxt;
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    rbyte_r   <= rbyte_nxt;
    row_r     <= row_nxt;
    cnt_r     <= cnt_nxt;
    hit_r     <= hit_nxt;
    res_r     <= res_nxt;
    va_r      <= va_nxt;
    vb_r      <= vb_nxt;
    bcd_h_r   <= bcd_h_nxt;
    bcd_rem_r <= bcd_rem_nxt;
    if (push_en) begin
      stk_r[sp_r[SP_IW-1:0]] <= pc_r;
    end
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for chip8_instruction_core
// A shadow CHIP-8 machine predicts the result of every accepted item. Small
// programs are written into memory one instruction at a time and executed,
// mixed with random memory, display and execute items, under random stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c8_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int PROGRAM_START = 512;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 850;

  // Shadow machine and the queue of results it has predicted.
  class chip8_shadow;
    logic [7:0]  mem [4096];
    logic [7:0]  v [16];
    logic [15:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [16];
    int          sp;
    logic [7:0]  dt, snd;
    logic [63:0] fb [32];
    logic        halted;
    out_item_t   due_results [$];
    int          errors;

    function new();
      foreach (mem[i]) mem[i] = (i < FONT_BYTES) ? FONT_GLYPHS[i] : 8'h00;
      foreach (v[i]) v[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      foreach (fb[i]) fb[i] = '0;
      idx = '0;
      pc = PROGRAM_START[11:0];
      sp = 0;
      dt = '0;
      snd = '0;
      halted = 1'b0;
      errors = 0;
    endfunction

    function logic [15:0] op_at_pc();
      return {mem[pc], mem[pc + 12'd1]};
    endfunction

    function logic [2:0] run_op(in_item_t it);
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, a, b;
      logic [11:0] nnn;
      logic [8:0]  sum;
      logic [2:0]  s;
      logic        held, hit;
      logic [63:0] bits;
      logic [5:0]  px;
      logic [4:0]  line;
      op = op_at_pc();
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      kk = op[7:0];
      nnn = op[11:0];
      s = ST_OK;
      pc = pc + 12'd2;
      case (op[15:12])
        4'h0: begin
          if (op == 16'h00E0) begin
            foreach (fb[i]) fb[i] = '0;
          end else if (op == 16'h00EE) begin
            if (sp == 0) begin
              halted = 1'b1;
              s = ST_STACK;
            end else begin
              sp--;
              pc = stk[sp];
            end
          end else begin
            s = ST_BADOP;
          end
        end
        4'h1: pc = nnn;
        4'h2: begin
          if (sp >= STACK_DEPTH) begin
            halted = 1'b1;
            s = ST_STACK;
          end else begin
            stk[sp] = pc;
            sp++;
            pc = nnn;
          end
        end
        4'h3: if (v[x] == kk) pc = pc + 12'd2;
        4'h4: if (v[x] != kk) pc = pc + 12'd2;
        4'h5: if (v[x] == v[y]) pc = pc + 12'd2;
        4'h6: v[x] = kk;
        4'h7: v[x] = v[x] + kk;
        4'h8: begin
          a = v[x];
          b = v[y];
          case (n)
            4'h0: v[x] = b;
            4'h1: v[x] = a | b;
            4'h2: v[x] = a & b;
            4'h3: v[x] = a ^ b;
            4'h4: begin
              sum = {1'b0, a} + {1'b0, b};
              v[15] = {7'd0, sum[8]};
              v[x] = sum[7:0];
            end
            4'h5: begin
              v[15] = {7'd0, a > b};
              v[x] = a - b;
            end
            4'h6: begin
              v[15] = {7'd0, a[0]};
              v[x] = a >> 1;
            end
            4'h7: begin
              v[15] = {7'd0, b > a};
              v[x] = b - a;
            end
            4'hE: begin
              v[15] = {7'd0, a[7]};
              v[x] = a << 1;
            end
            default: s = ST_BADOP;
          endcase
        end
        4'h9: if (v[x] != v[y]) pc = pc + 12'd2;
        4'hA: idx = {4'd0, nnn};
        4'hB: pc = nnn + {4'd0, v[0]};
        4'hC: v[x] = it.random_byte & kk;
        4'hD: begin
          px = v[x][5:0];
          hit = 1'b0;
          for (int r = 0; r < n; r++) begin
            bits = {mem[idx[11:0] + r[11:0]], 56'd0};
            line = v[y][4:0] + r[4:0];
            if (px != 0) bits = (bits >> px) | (bits << (7'd64 - px));
            if ((fb[line] & bits) != 0) hit = 1'b1;
            fb[line] = fb[line] ^ bits;
          end
          v[15] = {7'd0, hit};
        end
        4'hE: begin
          held = (v[x] < 16) && it.keys_down[v[x][3:0]];
          if (kk == 8'h9E) begin
            if (held) pc = pc + 12'd2;
          end else if (kk == 8'hA1) begin
            if (!held) pc = pc + 12'd2;
          end else begin
            s = ST_BADOP;
          end
        end
        default: begin
          case (kk)
            8'h07: v[x] = dt;
            8'h0A: begin
              if (it.key_press_event) begin
                v[x] = {4'd0, it.last_key};
              end else begin
                pc = pc - 12'd2;
                s = ST_WAIT;
              end
            end
            8'h15: dt = v[x];
            8'h18: snd = v[x];
            8'h1E: idx = idx + {8'd0, v[x]};
            8'h29: idx = v[x] * 16'd5;
            8'h33: begin
              mem[idx[11:0]] = v[x] / 100;
              mem[idx[11:0] + 12'd1] = (v[x] / 10) % 10;
              mem[idx[11:0] + 12'd2] = v[x] % 10;
            end
            8'h55: for (int c = 0; c <= x; c++) mem[idx[11:0] + c[11:0]] = v[c];
            8'h65: for (int c = 0; c <= x; c++) v[c] = mem[idx[11:0] + c[11:0]];
            default: s = ST_BADOP;
          endcase
        end
      endcase
      if (dt != 0) dt--;
      if (snd != 0) snd--;
      return s;
    endfunction

    function void accept_item(in_item_t it);
      out_item_t r;
      r = '0;
      r.step_status = halted ? ST_HALT : ST_OK;
      case (it.opcode)
        OPC_WRITE: mem[it.address] = it.write_byte;
        OPC_READ:  r.read_byte = mem[it.address];
        OPC_ROW:   r.display_row = fb[it.address[4:0]];
        default:   if (!halted) r.step_status = run_op(it);
      endcase
      r.program_counter = pc;
      r.sound_on = (snd != 0);
      due_results = {due_results, r};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t w;
      if (due_results.size() == 0) begin
        report("unexpected item", 64'(got.program_counter), 64'd0);
        return;
      end
      w = due_results.pop_front();
      if (got.read_byte !== w.read_byte)
        report("read_byte", 64'(got.read_byte), 64'(w.read_byte));
      if (got.display_row !== w.display_row)
        report("display_row", got.display_row, w.display_row);
      if (got.program_counter !== w.program_counter)
        report("program_counter", 64'(got.program_counter), 64'(w.program_counter));
      if (got.sound_on !== w.sound_on)
        report("sound_on", 64'(got.sound_on), 64'(w.sound_on));
      if (got.step_status !== w.step_status)
        report("step_status", 64'(got.step_status), 64'(w.step_status));
    endtask
  endclass

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;

  chip8_instruction_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .PROGRAM_START(PROGRAM_START)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  chip8_shadow shadow = new();
  int  items_sent;
  bit  hold_go, hold_done, no_gaps;
  int  idle_cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Results are taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.check_result(out_data);
  end

  // Cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver stalls; one long hold when the sender asks for it.
  initial begin
    int quiet;
    quiet = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (quiet > 0) begin
        quiet--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        quiet = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] opc, logic [11:0] addr, logic [7:0] wb);
    in_item_t it;
    it.opcode = opc;
    it.address = addr;
    it.write_byte = wb;
    it.keys_down = 16'($urandom());
    it.key_press_event = 1'($urandom_range(0, 1));
    it.last_key = 4'($urandom());
    it.random_byte = 8'($urandom());
    return it;
  endfunction

  // Offers one item from a falling edge and returns at a falling edge.
  task automatic send(in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    shadow.accept_item(it);
    items_sent++;
    @(negedge clk);
    g = $urandom_range(0, 99);
    if (!no_gaps && g >= 60) begin
      in_valid <= 1'b0;
      if (g >= 96) repeat ($urandom_range(10, 40)) @(negedge clk);
      else repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Places one instruction at the current PC and executes it.
  task automatic run_instr(logic [15:0] op);
    logic [11:0] at;
    at = shadow.pc;
    send(make_item(OPC_WRITE, at, op[15:8]));
    send(make_item(OPC_WRITE, at + 12'd1, op[7:0]));
    send(make_item(OPC_EXEC, 12'($urandom()), 8'($urandom())));
  endtask

  function automatic logic [15:0] pick_instr();
    logic [15:0] op;
    logic [3:0]  cls;
    logic [7:0]  fk [10];
    fk = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
    op = 16'($urandom());
    cls = op[15:12];
    case (cls)
      4'h0: begin
        case ($urandom_range(0, 3))
          0: op = 16'h00E0;
          1: op = (shadow.sp > 0) ? 16'h00EE : 16'h00E0;
          default: if (op[11:0] == 12'h0E0 || op[11:0] == 12'h0EE) op = 16'h0123;
        endcase
      end
      4'h2: if (shadow.sp >= STACK_DEPTH - 1) op[15:12] = 4'h1;
      4'h6: if ($urandom_range(0, 1)) op[7:0] = 8'($urandom_range(0, 20));
      4'h8: if ($urandom_range(0, 7) != 0) op[3:0] = $urandom_range(0, 8) == 8 ? 4'hE
                                                       : 4'($urandom_range(0, 7));
      4'hE: begin
        case ($urandom_range(0, 4))
          0, 1: op[7:0] = 8'h9E;
          2, 3: op[7:0] = 8'hA1;
          default: ;
        endcase
      end
      4'hF: begin
        op[7:0] = fk[$urandom_range(0, 9)];
        if (op[7:0] == 8'h00) op[7:0] = 8'h77;
        // Timers loaded with big values would keep sound on for a long time.
        if (op[7:0] == 8'h15 || op[7:0] == 8'h18) begin
          if ($urandom_range(0, 3) != 0) op = 16'h6000 | {4'd0, op[11:8], 8'd0}
                                           | {8'd0, 8'($urandom_range(0, 12))};
        end
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic noise_item();
    logic [15:0] cur;
    case ($urandom_range(0, 3))
      0: send(make_item(OPC_WRITE, 12'($urandom()), 8'($urandom())));
      1: send(make_item(OPC_READ, 12'($urandom()), 8'($urandom())));
      2: send(make_item(OPC_ROW, 12'($urandom()), 8'($urandom())));
      default: begin
        // Run whatever already sits at PC unless it touches the stack.
        cur = shadow.op_at_pc();
        if (cur[15:12] != 4'h2 && cur != 16'h00EE)
          send(make_item(OPC_EXEC, 12'($urandom()), 8'($urandom())));
        else
          send(make_item(OPC_ROW, 12'($urandom()), 8'($urandom())));
      end
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    items_sent = 0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    no_gaps = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, address wrap, key wait, empty sprite.
    send(make_item(OPC_READ, 12'h000, 8'h00));
    send(make_item(OPC_WRITE, 12'hFFF, 8'hFF));
    send(make_item(OPC_READ, 12'hFFF, 8'h00));
    send(make_item(OPC_ROW, 12'h000, 8'h00));
    send(make_item(OPC_ROW, 12'hFFF, 8'h00));
    run_instr(16'h6FFF);
    run_instr(16'hD010);
    run_instr(16'h1FFF);
    run_instr(16'hF80A);
    run_instr(16'hE09E);
    send(make_item(OPC_READ, 12'h000, 8'h00));

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > 300 && !hold_go) hold_go = 1'b1;
      if (items_sent > 600 && items_sent < 604) begin
        in_valid <= 1'b0;
        while (shadow.due_results.size() != 0) @(negedge clk);
      end
      no_gaps = (items_sent % 200) > 170;
      if ($urandom_range(0, 4) == 0) noise_item();
      else run_instr(pick_instr());
    end

    // Finish with a stack fault and a few items while halted.
    if ($urandom_range(0, 1)) begin
      while (shadow.sp < STACK_DEPTH) run_instr({4'h2, 12'($urandom())});
      run_instr({4'h2, 12'($urandom())});
    end else begin
      while (shadow.sp > 0) run_instr(16'h00EE);
      run_instr(16'h00EE);
    end
    repeat (4) noise_item();
    send(make_item(OPC_EXEC, 12'($urandom()), 8'($urandom())));
    in_valid <= 1'b0;

    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
